[rtl/page_refcount_allocator_macros.svh]
// assertion macros used by the checker module
`ifndef PAGE_REFCOUNT_ALLOCATOR_MACROS_SVH
`define PAGE_REFCOUNT_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define PRA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define PRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pra_pkg.sv]
package pra_pkg;

  localparam int OPCODE_W = 3;
  localparam int PAGE_W   = 16;
  localparam int RPAGE_W  = 15;
  localparam int COUNT_W  = 8;
  localparam int STATUS_W = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INIT  = 3'd0,
    OP_ALLOC = 3'd1,
    OP_FREE  = 3'd2,
    OP_INC   = 3'd3,
    OP_DEC   = 3'd4,
    OP_QUERY = 3'd5
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 3'd0,
    STATUS_EMPTY    = 3'd1,
    STATUS_RANGE    = 3'd2,
    STATUS_UNREF    = 3'd3,
    STATUS_CORRUPT  = 3'd4,
    STATUS_OVERFLOW = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_TOP,
    S_WALK,
    S_EXEC
  } state_e;

endpackage

[rtl/pra_intf.sv]
interface pra_req_if;
  import pra_pkg::*;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [PAGE_W-1:0]   page;
  modport source (output valid, opcode, page, input ready);
  modport sink (input valid, opcode, page, output ready);
endinterface

interface pra_rsp_if;
  import pra_pkg::*;
  logic                valid;
  logic                ready;
  logic [RPAGE_W-1:0]  result_page;
  logic [COUNT_W-1:0]  ref_count;
  logic                returned_to_pool;
  logic [STATUS_W-1:0] status;
  modport source (output valid, result_page, ref_count, returned_to_pool, status,
                  input ready);
  modport sink (input valid, result_page, ref_count, returned_to_pool, status,
                output ready);
endinterface

interface pra_cfg_if;
  import pra_pkg::*;
  logic               valid;
  logic               ready;
  logic [RPAGE_W-1:0] first_page;
  modport source (output valid, first_page, input ready);
  modport sink (input valid, first_page, output ready);
endinterface

[rtl/page_refcount_allocator.sv]
// free, increment, decrement and query read the page's count, then build the result; alloc
// first reads the stack top, then the count of that page, both through registered read ports
// init writes one count and one stack entry per page from first_page to the last page
// one request at a time: none is taken until its result is loaded; a finished result waits
// in the output register; reset is asynchronous, active low; afterwards a clearing pass
// zeroes every count, during which no request is taken (configuration still is)
module page_refcount_allocator #(
  parameter int NUM_PAGES = 32768
) (
  input logic        clk_i,
  input logic        rst_ni,
  pra_cfg_if.sink    cfg_i,
  pra_req_if.sink    req_i,
  pra_rsp_if.source  rsp_o
);
  import pra_pkg::*;

  localparam int AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int DW = $clog2(NUM_PAGES + 1);
  localparam logic [31:0]   NUM_PAGES_U = 32'(NUM_PAGES);
  localparam logic [AW-1:0] LAST_PAGE   = AW'(NUM_PAGES - 1);

  state_e state_q, state_d;
  logic [AW-1:0]      walk_q, walk_d;
  logic [DW-1:0]      depth_q, depth_d;
  logic [RPAGE_W-1:0] first_page_q;

  opcode_e            op_q;
  logic [PAGE_W-1:0]  page_q;
  logic               in_table_q;

  logic [COUNT_W-1:0] cnt_mem [NUM_PAGES];
  logic [AW-1:0]      stk_mem [NUM_PAGES];

  logic               cnt_re, cnt_we;
  logic [AW-1:0]      cnt_raddr, cnt_waddr;
  logic [COUNT_W-1:0] cnt_wdata, cnt_rdata_q;
  logic               stk_re, stk_we;
  logic [AW-1:0]      stk_raddr, stk_waddr, stk_wdata, stk_rdata_q;

  logic               rsp_valid_q, rsp_valid_d, rsp_load;
  logic [RPAGE_W-1:0] rsp_page_q, rsp_page_d;
  logic [COUNT_W-1:0] rsp_count_q, rsp_count_d;
  logic               rsp_ret_q, rsp_ret_d;
  status_e            rsp_status_q, rsp_status_d;

  logic               req_accept, in_table_in, walk_start, out_free;
  logic [COUNT_W-1:0] cur_cnt, new_cnt;
  logic [AW-1:0]      page_addr;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == S_IDLE);
  assign req_accept  = req_i.valid && req_i.ready;
  assign in_table_in = 32'(req_i.page) < NUM_PAGES_U;
  assign walk_start  = 32'(first_page_q) < NUM_PAGES_U;
  assign out_free    = !rsp_valid_q || rsp_o.ready;

  assign cur_cnt   = in_table_q ? cnt_rdata_q : '0;
  assign page_addr = AW'(page_q);

  always_comb begin
    state_d      = state_q;
    walk_d       = walk_q;
    depth_d      = depth_q;
    cnt_re       = 1'b0;
    cnt_raddr    = AW'(req_i.page);
    cnt_we       = 1'b0;
    cnt_waddr    = walk_q;
    cnt_wdata    = '0;
    stk_re       = 1'b0;
    stk_raddr    = AW'(depth_q - DW'(1));
    stk_we       = 1'b0;
    stk_waddr    = depth_q[AW-1:0];
    stk_wdata    = walk_q;
    rsp_load     = 1'b0;
    rsp_page_d   = '0;
    rsp_count_d  = '0;
    rsp_ret_d    = 1'b0;
    rsp_status_d = STATUS_OK;
    new_cnt      = '0;

    unique case (state_q)
      S_CLEAR: begin
        cnt_we = 1'b1;
        if (walk_q == LAST_PAGE) begin
          walk_d  = '0;
          state_d = S_IDLE;
        end else begin
          walk_d = walk_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (req_accept) begin
          cnt_re = 1'b1;
          stk_re = 1'b1;
          if (opcode_e'(req_i.opcode) == OP_INIT) begin
            depth_d = '0;
            if (walk_start) begin
              walk_d  = AW'(first_page_q);
              state_d = S_WALK;
            end else begin
              state_d = S_EXEC;
            end
          end else if (opcode_e'(req_i.opcode) == OP_ALLOC) begin
            state_d = S_TOP;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_TOP: begin
        // count of the page on top of the stack
        cnt_re    = 1'b1;
        cnt_raddr = stk_rdata_q;
        state_d   = S_EXEC;
      end
      S_WALK: begin
        cnt_we  = 1'b1;
        stk_we  = 1'b1;
        depth_d = depth_q + DW'(1);
        if (walk_q == LAST_PAGE) begin
          state_d = S_EXEC;
        end else begin
          walk_d = walk_q + AW'(1);
        end
      end
      S_EXEC: begin
        if (out_free) begin
          rsp_load = 1'b1;
          state_d  = S_IDLE;
          unique case (op_q)
            OP_INIT: begin
              rsp_status_d = STATUS_OK;
            end
            OP_ALLOC: begin
              if (depth_q == '0) begin
                rsp_status_d = STATUS_EMPTY;
              end else begin
                rsp_page_d = RPAGE_W'(stk_rdata_q);
                if (cnt_rdata_q != '0) begin
                  rsp_count_d  = cnt_rdata_q;
                  rsp_status_d = STATUS_CORRUPT;
                end else begin
                  cnt_we      = 1'b1;
                  cnt_waddr   = stk_rdata_q;
                  cnt_wdata   = COUNT_W'(1);
                  depth_d     = depth_q - DW'(1);
                  rsp_count_d = COUNT_W'(1);
                end
              end
            end
            OP_FREE: begin
              rsp_page_d  = page_q[RPAGE_W-1:0];
              rsp_count_d = cur_cnt;
              if (!in_table_q || (page_q < PAGE_W'(first_page_q))) begin
                rsp_status_d = STATUS_RANGE;
              end else if (cur_cnt == '0) begin
                rsp_status_d = STATUS_UNREF;
              end else begin
                new_cnt     = cur_cnt - COUNT_W'(1);
                cnt_we      = 1'b1;
                cnt_waddr   = page_addr;
                cnt_wdata   = new_cnt;
                rsp_count_d = new_cnt;
                // last reference gone: page goes back on the stack unless it is full
                if ((new_cnt == '0) && (32'(depth_q) < NUM_PAGES_U)) begin
                  stk_we    = 1'b1;
                  stk_wdata = page_addr;
                  depth_d   = depth_q + DW'(1);
                  rsp_ret_d = 1'b1;
                end
              end
            end
            OP_INC, OP_DEC: begin
              rsp_page_d  = page_q[RPAGE_W-1:0];
              rsp_count_d = cur_cnt;
              if (!in_table_q) begin
                rsp_status_d = STATUS_RANGE;
              end else if (cur_cnt == '0) begin
                rsp_status_d = STATUS_UNREF;
              end else if ((op_q == OP_INC) && (cur_cnt == COUNT_MAX)) begin
                rsp_status_d = STATUS_OVERFLOW;
              end else begin
                new_cnt     = (op_q == OP_INC) ? cur_cnt + COUNT_W'(1)
                                               : cur_cnt - COUNT_W'(1);
                cnt_we      = 1'b1;
                cnt_waddr   = page_addr;
                cnt_wdata   = new_cnt;
                rsp_count_d = new_cnt;
              end
            end
            default: begin
              // query, and the unused codes
              rsp_page_d   = page_q[RPAGE_W-1:0];
              rsp_count_d  = cur_cnt;
              rsp_status_d = in_table_q ? STATUS_OK : STATUS_RANGE;
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (rsp_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      walk_q       <= '0;
      depth_q      <= '0;
      first_page_q <= '0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      walk_q      <= walk_d;
      depth_q     <= depth_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        first_page_q <= cfg_i.first_page;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      op_q       <= opcode_e'(req_i.opcode);
      page_q     <= req_i.page;
      in_table_q <= in_table_in;
    end
    if (rsp_load) begin
      rsp_page_q   <= rsp_page_d;
      rsp_count_q  <= rsp_count_d;
      rsp_ret_q    <= rsp_ret_d;
      rsp_status_q <= rsp_status_d;
    end
  end

  // reference count memory
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rdata_q <= cnt_mem[cnt_raddr];
    end
  end

  // free stack memory
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rdata_q <= stk_mem[stk_raddr];
    end
  end

  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.result_page      = rsp_page_q;
  assign rsp_o.ref_count        = rsp_count_q;
  assign rsp_o.returned_to_pool = rsp_ret_q;
  assign rsp_o.status           = rsp_status_q;

endmodule

[rtl/pra_checker.sv]
`include "page_refcount_allocator_macros.svh"

module pra_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [pra_pkg::RPAGE_W-1:0]   rsp_result_page_i,
  input logic [pra_pkg::COUNT_W-1:0]   rsp_ref_count_i,
  input logic                          rsp_returned_to_pool_i,
  input logic [pra_pkg::STATUS_W-1:0]  rsp_status_i
);
  import pra_pkg::*;

  logic rsp_stall;
  assign rsp_stall = rsp_valid_i && !rsp_ready_i;

  // one operation in flight: no request taken right after a beat
  `PRA_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i, "request taken while busy")

  // a page pushed back on the stack has no references left
  `PRA_ASSERT_IMPLY(a_push_zero, clk_i, rst_ni, rsp_valid_i && rsp_returned_to_pool_i, (rsp_ref_count_i == '0) && (rsp_status_i == STATUS_OK), "pushed page with references")

  // empty stack reports page and count zero
  `PRA_ASSERT_IMPLY(a_empty_zero, clk_i, rst_ni, rsp_valid_i && (rsp_status_i == STATUS_EMPTY), (rsp_result_page_i == '0) && (rsp_ref_count_i == '0) && !rsp_returned_to_pool_i, "empty result not zero")

  `PRA_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_stall, rsp_valid_i, "result beat dropped")

  `PRA_ASSERT_NEXT(a_rsp_stable, clk_i, rst_ni, rsp_stall, $stable(rsp_result_page_i) && $stable(rsp_ref_count_i) && $stable(rsp_returned_to_pool_i) && $stable(rsp_status_i), "stalled result changed")

endmodule

bind page_refcount_allocator pra_checker u_pra_checker (
  .clk_i                  (clk_i),
  .rst_ni                 (rst_ni),
  .req_valid_i            (req_i.valid),
  .req_ready_i            (req_i.ready),
  .rsp_valid_i            (rsp_o.valid),
  .rsp_ready_i            (rsp_o.ready),
  .rsp_result_page_i      (rsp_o.result_page),
  .rsp_ref_count_i        (rsp_o.ref_count),
  .rsp_returned_to_pool_i (rsp_o.returned_to_pool),
  .rsp_status_i           (rsp_o.status)
);

[bench/page_alloc_checker.sv]
module page_alloc_checker #(
  parameter int NUM_PAGES = 32768
) (
  input  logic clk_i,
  input  logic rst_ni,
  pra_cfg_if   cfg_i,
  pra_req_if   req_i,
  pra_rsp_if   rsp_i,
  output int   mismatch_count_o,
  output int   pending_count_o,
  output int   checked_count_o,
  output int   returned_count_o,
  output int   empty_count_o,
  output int   range_count_o,
  output int   unref_count_o,
  output int   overflow_count_o
);
  import pra_pkg::*;

  typedef struct packed {
    logic [RPAGE_W-1:0] result_page;
    logic [COUNT_W-1:0] ref_count;
    logic               returned_to_pool;
    status_e            status;
  } page_result_t;

  logic [COUNT_W-1:0] page_counts  [NUM_PAGES];
  logic [RPAGE_W-1:0] shadow_stack [NUM_PAGES];
  int                 free_depth;
  logic [RPAGE_W-1:0] first_page_q;
  page_result_t       pending_page_results [$];

  int mismatches;
  int checked;
  int returned;
  int empties;
  int ranges;
  int unrefs;
  int overflows;

  // applies one operation to the shadow allocator and returns its result
  function automatic page_result_t apply_page_op(input logic [OPCODE_W-1:0] op,
                                                 input logic [PAGE_W-1:0]   pg);
    page_result_t       r;
    int                 idx;
    int                 top_page;
    logic               in_table;
    logic [COUNT_W-1:0] cnt;
    idx      = pg;
    in_table = idx < NUM_PAGES;
    cnt      = in_table ? page_counts[idx] : '0;
    r.result_page      = pg[RPAGE_W-1:0];
    r.ref_count        = cnt;
    r.returned_to_pool = 1'b0;
    r.status           = STATUS_OK;
    case (op)
      OP_INIT: begin
        free_depth = 0;
        for (int p = first_page_q; p < NUM_PAGES; p++) begin
          page_counts[p]           = '0;
          shadow_stack[free_depth] = RPAGE_W'(p);
          free_depth++;
        end
        r.result_page = '0;
        r.ref_count   = '0;
      end
      OP_ALLOC: begin
        if (free_depth == 0) begin
          r.result_page = '0;
          r.ref_count   = '0;
          r.status      = STATUS_EMPTY;
        end else begin
          top_page      = shadow_stack[free_depth-1] % NUM_PAGES;
          r.result_page = RPAGE_W'(top_page);
          r.ref_count   = page_counts[top_page];
          if (page_counts[top_page] != '0) begin
            // page on the stack still referenced, left in place
            r.status = STATUS_CORRUPT;
          end else begin
            page_counts[top_page] = COUNT_W'(1);
            r.ref_count           = COUNT_W'(1);
            free_depth--;
          end
        end
      end
      OP_FREE: begin
        if (!in_table || idx < first_page_q) begin
          r.status = STATUS_RANGE;
        end else if (cnt == '0) begin
          r.status = STATUS_UNREF;
        end else begin
          cnt              = cnt - 1'b1;
          page_counts[idx] = cnt;
          r.ref_count      = cnt;
          if (cnt == '0 && free_depth < NUM_PAGES) begin
            shadow_stack[free_depth] = RPAGE_W'(idx);
            free_depth++;
            r.returned_to_pool = 1'b1;
          end
        end
      end
      OP_INC, OP_DEC: begin
        if (!in_table) begin
          r.ref_count = '0;
          r.status    = STATUS_RANGE;
        end else if (cnt == '0) begin
          r.status = STATUS_UNREF;
        end else if (op == OP_INC && cnt == COUNT_MAX) begin
          r.status = STATUS_OVERFLOW;
        end else begin
          // decrement to zero leaves the page off the stack
          cnt              = (op == OP_INC) ? cnt + 1'b1 : cnt - 1'b1;
          page_counts[idx] = cnt;
          r.ref_count      = cnt;
        end
      end
      default: begin
        // query and the two spare codes
        if (!in_table) begin
          r.ref_count = '0;
          r.status    = STATUS_RANGE;
        end
      end
    endcase
    return r;
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    page_result_t want;
    if (!rst_ni) begin
      foreach (page_counts[i]) page_counts[i] = '0;
      free_depth   = 0;
      first_page_q = '0;
      pending_page_results.delete();
      mismatches = 0;
      checked    = 0;
      returned   = 0;
      empties    = 0;
      ranges     = 0;
      unrefs     = 0;
      overflows  = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (pending_page_results.size() == 0) begin
          $error("result beat with nothing predicted: page %0d, status %0d",
                 rsp_i.result_page, rsp_i.status);
          mismatches++;
        end else begin
          want = pending_page_results.pop_front();
          compare_field("result_page", want.result_page, rsp_i.result_page);
          compare_field("ref_count", want.ref_count, rsp_i.ref_count);
          compare_field("returned_to_pool", want.returned_to_pool, rsp_i.returned_to_pool);
          compare_field("status", want.status, rsp_i.status);
          checked++;
          if (want.returned_to_pool) returned++;
          case (want.status)
            STATUS_EMPTY:    empties++;
            STATUS_RANGE:    ranges++;
            STATUS_UNREF:    unrefs++;
            STATUS_OVERFLOW: overflows++;
            default: ;
          endcase
        end
      end
      if (cfg_i.valid && cfg_i.ready) first_page_q = cfg_i.first_page;
      if (req_i.valid && req_i.ready) begin
        pending_page_results.push_back(apply_page_op(req_i.opcode, req_i.page));
      end
    end
    mismatch_count_o <= mismatches;
    pending_count_o  <= pending_page_results.size();
    checked_count_o  <= checked;
    returned_count_o <= returned;
    empty_count_o    <= empties;
    range_count_o    <= ranges;
    unref_count_o    <= unrefs;
    overflow_count_o <= overflows;
  end

endmodule

[bench/tb_page_refcount_allocator.sv]
module tb_page_refcount_allocator;
  import pra_pkg::*;

  localparam int NUM_PAGES   = 32768;
  // init and the clearing pass after reset both walk the page table
  localparam int STALL_LIMIT = 4 * NUM_PAGES + 2000;
  localparam int LONG_HOLD   = 400;
  localparam int HOLD_AFTER  = 100;

  localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;
  localparam logic [PAGE_W-1:0]   LAST_PAGE   = PAGE_W'(NUM_PAGES - 1);

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pra_cfg_if cfg_if ();
  pra_req_if req_if ();
  pra_rsp_if rsp_if ();

  int   mismatches;
  int   pending;
  int   checked;
  int   returned;
  int   empties;
  int   ranges;
  int   unrefs;
  int   overflows;
  int   quiet_cycles = 0;
  int   first_page_now = 0;
  int   settings_used = 0;
  bit   steady = 1'b0;
  logic any_beat;

  always #5 clk_i = ~clk_i;

  page_refcount_allocator #(
    .NUM_PAGES(NUM_PAGES)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  page_alloc_checker #(
    .NUM_PAGES(NUM_PAGES)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_if),
    .req_i           (req_if),
    .rsp_i           (rsp_if),
    .mismatch_count_o(mismatches),
    .pending_count_o (pending),
    .checked_count_o (checked),
    .returned_count_o(returned),
    .empty_count_o   (empties),
    .range_count_o   (ranges),
    .unref_count_o   (unrefs),
    .overflow_count_o(overflows)
  );

  assign any_beat = (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                    (cfg_if.valid && cfg_if.ready);

  always @(posedge clk_i) begin
    if (!rst_ni || any_beat) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(12, 45);
  endfunction

  // mostly pages near the top of the stack, where allocs and frees meet
  function automatic logic [PAGE_W-1:0] pick_page();
    int roll;
    int span;
    roll = $urandom_range(0, 99);
    span = NUM_PAGES - first_page_now;
    if (span > 24) span = 24;
    if (roll < 70) return PAGE_W'(NUM_PAGES - 1 - $urandom_range(0, span - 1));
    if (roll < 80) return PAGE_W'($urandom_range(first_page_now, NUM_PAGES - 1));
    if (roll < 88 && first_page_now > 0) return PAGE_W'($urandom_range(0, first_page_now - 1));
    return PAGE_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [OPCODE_W-1:0] pick_op();
    int roll;
    roll = $urandom_range(0, 99);
    // re-init only where the walk is short
    if (roll < 2 && NUM_PAGES - first_page_now <= 256) return OP_INIT;
    if (roll < 32) return OP_ALLOC;
    if (roll < 56) return OP_FREE;
    if (roll < 76) return OP_INC;
    if (roll < 86) return OP_DEC;
    if (roll < 91) return OP_QUERY;
    return OPCODE_W'($urandom_range(1, 7));
  endfunction

  // valid stays high into the next beat when there is no gap
  task automatic send(input logic [OPCODE_W-1:0] op, input logic [PAGE_W-1:0] pg);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid  <= 1'b1;
    req_if.opcode <= op;
    req_if.page   <= pg;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic settle();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic set_first_page(input logic [RPAGE_W-1:0] value);
    settle();
    cfg_if.valid      <= 1'b1;
    cfg_if.first_page <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid   <= 1'b0;
    first_page_now = value;
    settings_used++;
  endtask

  task automatic run_phase(input logic [RPAGE_W-1:0] first_pg, input int count,
                           input bit pump);
    set_first_page(first_pg);
    send(OP_INIT, PAGE_W'($urandom_range(0, 65535)));
    if (pump) begin
      // drive the top page's count up into saturation, back to back
      steady = 1'b1;
      send(OP_ALLOC, '0);
      repeat (COUNT_MAX + 1) send(OP_INC, LAST_PAGE);
      repeat (3) send(OP_DEC, LAST_PAGE);
      steady = 1'b0;
    end
    repeat (count) begin
      if ($urandom_range(0, 49) == 0) settle();
      send(pick_op(), pick_page());
    end
  endtask

  initial begin : result_sink
    int  roll;
    int  stall;
    bit  held;
    held = 1'b0;
    rsp_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && checked >= HOLD_AFTER) begin
        // long back-pressure so the block fills and stalls its input
        held = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
        rsp_if.ready <= 1'b1;
        repeat ($urandom_range(20, 80)) @(posedge clk_i);
      end else begin
        stall = (roll < 35) ? $urandom_range(10, 40) : $urandom_range(0, 3);
        if (stall > 0) begin
          rsp_if.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        rsp_if.ready <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    req_if.valid      <= 1'b0;
    req_if.opcode     <= '0;
    req_if.page       <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.first_page <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty stack after reset, range and unreferenced paths, spare codes
    send(OP_ALLOC, '0);
    send(OP_QUERY, '0);
    send(OP_QUERY, '1);
    send(OP_INC, LAST_PAGE);
    send(OP_DEC, PAGE_W'(NUM_PAGES + 7232));
    send(OP_FREE, '1);
    send(OP_FREE, PAGE_W'(5));
    send(OP_SPARE_LO, PAGE_W'(3));
    send(OP_SPARE_HI, PAGE_W'(NUM_PAGES + 1));

    // two managed pages: lifo order, exhaustion, push on free, no push on dec
    set_first_page(RPAGE_W'(NUM_PAGES - 2));
    send(OP_INIT, '0);
    send(OP_ALLOC, '0);
    send(OP_ALLOC, '0);
    send(OP_ALLOC, '0);
    send(OP_INC, LAST_PAGE);
    send(OP_DEC, LAST_PAGE);
    send(OP_FREE, LAST_PAGE);
    send(OP_FREE, LAST_PAGE - 1'b1);
    send(OP_FREE, LAST_PAGE - 1'b1);
    send(OP_FREE, LAST_PAGE - 2'd2);
    send(OP_INC, LAST_PAGE - 1'b1);
    send(OP_QUERY, LAST_PAGE - 1'b1);
    send(OP_ALLOC, '0);
    send(OP_DEC, LAST_PAGE - 1'b1);
    send(OP_ALLOC, '0);
    send(OP_ALLOC, '0);

    run_phase(RPAGE_W'(NUM_PAGES - 1), 40, 1'b0);
    run_phase('0, 40, 1'b1);
    run_phase(RPAGE_W'(NUM_PAGES - $urandom_range(8, 48)), 130, 1'b0);
    run_phase(RPAGE_W'($urandom_range(1, NUM_PAGES - 2)), 60, 1'b0);

    settle();
    repeat (8) @(posedge clk_i);
    $display("checked %0d results over %0d first-page settings, %0d frees returned a page",
             checked, settings_used, returned);
    $display("error paths hit: %0d empty, %0d out of range, %0d unreferenced, %0d overflow",
             empties, ranges, unrefs, overflows);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
